// File: hdl/tetrahedron_circumsphere_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tetrahedron circumsphere core
// Shared concurrent-assertion wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TETRAHEDRON_CIRCUMSPHERE_CORE_DEFINES_SVH
`define TETRAHEDRON_CIRCUMSPHERE_CORE_DEFINES_SVH

// same-cycle implication
`define TCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed delay
`define TCC_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths and transfer types for the tetrahedron circumsphere core.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int CW   = 32;            // coordinate width
  localparam int DW   = CW + 1;        // edge vector component
  localparam int NW   = 2 * DW + 1;    // cross product component
  localparam int SW   = 2 * DW + 2;    // squared edge length
  localparam int TW   = 3 * DW + 3;    // determinant, m vector
  localparam int DENW = 3 * DW + 4;    // twice the determinant
  localparam int NUMW = 4 * DW + 5;    // numerator of the center offset
  localparam int QW   = CW + 2;        // quotient bits resolved exactly
  localparam int RW   = 63;            // squared radius width

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    logic signed [CW-1:0] d_x;
    logic signed [CW-1:0] d_y;
    logic signed [CW-1:0] d_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [RW-1:0]        radius_squared;
    logic                 degenerate;
  } out_item_t;

endpackage

// File: hdl/tetrahedron_circumsphere_core.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere_core
// Circumcenter and squared circumradius of a tetrahedron, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: drive in_item with the four vertices (signed Q16.16) and
//    pulse start. A transfer happens on every edge with start high and busy
//    low; busy is always low, so one tetrahedron may enter every cycle.
//  - Result channel: out_valid is high for exactly one cycle per transfer,
//    with out_item holding center (Q16.16, saturated), squared radius
//    (Q31.32, saturated) and the degenerate flag (zero determinant, all
//    other fields zero). Results come out in input order.
//  - Throughput: one item per cycle, set by the pipeline: 10 stages of
//    products and sums (wide products built from 33x33 partial products
//    over several stages), one abs/overflow stage, one restoring-divide
//    stage per quotient bit (34), then round, center and square, and the
//    radius sum into the output register.
//  - The receiver cannot stall; results are never held back.
//  - Reset (rst_n low, synchronous) clears only the valid chain; items in
//    flight are dropped and no result shows until new items enter.
// ----------------------------------------------------------------------------
`include "tetrahedron_circumsphere_core_defines.svh"

module tetrahedron_circumsphere_core
  import tcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int LAT = QW + 14;
  localparam int EW  = QW + 2;      // center sum width
  localparam int PW  = DW + TW;     // u x m product
  localparam int SNW = SW + NW;     // su * n product

  typedef logic signed [DW-1:0] vec_t [3];

  // 32-bit limbs as 33-bit signed multiplier operands
  typedef logic [2:0][DW-1:0] limb3_t;
  typedef logic [3:0][DW-1:0] limb4_t;

  // divider stage payload
  typedef struct packed {
    logic [2:0][NUMW-1:0] rem;
    logic [2:0][QW-1:0]   quo;
    logic [2:0]           neg;
    logic [2:0]           ovf;
    logic [DENW-1:0]      dmag;
    logic                 deg;
    logic [2:0][CW-1:0]   a;
  } div_t;

  // low limbs zero-extended, top limb sign-extended
  function automatic limb3_t limbs3(input logic [SW-1:0] x);
    limb3_t l;
    l[0] = {1'b0, x[31:0]};
    l[1] = {1'b0, x[63:32]};
    l[2] = DW'($signed(x[SW-1:64]));
    return l;
  endfunction

  function automatic limb4_t limbs4(input logic [TW-1:0] x);
    limb4_t l;
    l[0] = {1'b0, x[31:0]};
    l[1] = {1'b0, x[63:32]};
    l[2] = {1'b0, x[95:64]};
    l[3] = DW'($signed(x[TW-1:96]));
    return l;
  endfunction

  logic [LAT-1:0] vld_r;

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // ---------------- stage 1: edge vectors from vertex A
  vec_t u_r, v_r, w_r;
  logic signed [CW-1:0] a1_r [3];

  always_ff @(posedge clk) begin
    a1_r[0] <= in_item.a_x;
    a1_r[1] <= in_item.a_y;
    a1_r[2] <= in_item.a_z;
    u_r[0]  <= DW'(in_item.b_x) - DW'(in_item.a_x);
    u_r[1]  <= DW'(in_item.b_y) - DW'(in_item.a_y);
    u_r[2]  <= DW'(in_item.b_z) - DW'(in_item.a_z);
    v_r[0]  <= DW'(in_item.c_x) - DW'(in_item.a_x);
    v_r[1]  <= DW'(in_item.c_y) - DW'(in_item.a_y);
    v_r[2]  <= DW'(in_item.c_z) - DW'(in_item.a_z);
    w_r[0]  <= DW'(in_item.d_x) - DW'(in_item.a_x);
    w_r[1]  <= DW'(in_item.d_y) - DW'(in_item.a_y);
    w_r[2]  <= DW'(in_item.d_z) - DW'(in_item.a_z);
  end

  // ---------------- stage 2: products for n = w x v and the squares
  logic signed [2*DW-1:0] pc_r [6];
  logic signed [2*DW-1:0] pu_r [3], pv_r [3], pw_r [3];
  vec_t u2_r, v2_r, w2_r;
  logic signed [CW-1:0] a2_r [3];

  always_ff @(posedge clk) begin
    pc_r[0] <= w_r[1] * v_r[2];
    pc_r[1] <= w_r[2] * v_r[1];
    pc_r[2] <= w_r[2] * v_r[0];
    pc_r[3] <= w_r[0] * v_r[2];
    pc_r[4] <= w_r[0] * v_r[1];
    pc_r[5] <= w_r[1] * v_r[0];
    for (int k = 0; k < 3; k++) begin
      pu_r[k] <= u_r[k] * u_r[k];
      pv_r[k] <= v_r[k] * v_r[k];
      pw_r[k] <= w_r[k] * w_r[k];
    end
    u2_r <= u_r;
    v2_r <= v_r;
    w2_r <= w_r;
    a2_r <= a1_r;
  end

  // ---------------- stage 3: n and squared lengths
  logic signed [NW-1:0] n3_r [3];
  logic signed [SW-1:0] su3_r, sv3_r, sw3_r;
  vec_t u3_r, v3_r, w3_r;
  logic signed [CW-1:0] a3_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n3_r[k] <= NW'(pc_r[2*k]) - NW'(pc_r[2*k+1]);
    end
    su3_r <= SW'(pu_r[0]) + SW'(pu_r[1]) + SW'(pu_r[2]);
    sv3_r <= SW'(pv_r[0]) + SW'(pv_r[1]) + SW'(pv_r[2]);
    sw3_r <= SW'(pw_r[0]) + SW'(pw_r[1]) + SW'(pw_r[2]);
    u3_r  <= u2_r;
    v3_r  <= v2_r;
    w3_r  <= w2_r;
    a3_r  <= a2_r;
  end

  // ---------------- stage 4: partial products for u . n, sv*w and sw*v
  limb3_t nl3 [3];
  limb3_t svl3, swl3;

  always_comb begin
    for (int k = 0; k < 3; k++) nl3[k] = limbs3(SW'(n3_r[k]));
  end

  assign svl3 = limbs3(sv3_r);
  assign swl3 = limbs3(sw3_r);

  logic signed [2*DW-1:0] ppd_r [3][3];
  logic signed [2*DW-1:0] ppm1_r [3][3], ppm2_r [3][3];
  logic signed [NW-1:0] n4_r [3];
  logic signed [SW-1:0] su4_r;
  vec_t u4_r;
  logic signed [CW-1:0] a4_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        ppd_r[k][j]  <= u3_r[k] * $signed(nl3[k][j]);
        ppm1_r[k][j] <= w3_r[k] * $signed(svl3[j]);
        ppm2_r[k][j] <= v3_r[k] * $signed(swl3[j]);
      end
    end
    n4_r  <= n3_r;
    su4_r <= su3_r;
    u4_r  <= u3_r;
    a4_r  <= a3_r;
  end

  // ---------------- stage 5: determinant terms and m terms
  logic signed [DW+NW-1:0] pd_r [3];
  logic signed [SW+DW-1:0] pm1_r [3], pm2_r [3];
  logic signed [NW-1:0] n5_r [3];
  logic signed [SW-1:0] su5_r;
  vec_t u5_r;
  logic signed [CW-1:0] a5_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pd_r[k]  <= (DW+NW)'(ppd_r[k][0]) + ((DW+NW)'(ppd_r[k][1]) <<< 32) +
                  ((DW+NW)'(ppd_r[k][2]) <<< 64);
      pm1_r[k] <= (SW+DW)'(ppm1_r[k][0]) + ((SW+DW)'(ppm1_r[k][1]) <<< 32) +
                  ((SW+DW)'(ppm1_r[k][2]) <<< 64);
      pm2_r[k] <= (SW+DW)'(ppm2_r[k][0]) + ((SW+DW)'(ppm2_r[k][1]) <<< 32) +
                  ((SW+DW)'(ppm2_r[k][2]) <<< 64);
    end
    n5_r  <= n4_r;
    su5_r <= su4_r;
    u5_r  <= u4_r;
    a5_r  <= a4_r;
  end

  // ---------------- stage 6: det = u . n, m = sv*w - sw*v
  logic signed [TW-1:0] det6_r;
  logic signed [TW-1:0] m6_r [3];
  logic signed [NW-1:0] n6_r [3];
  logic signed [SW-1:0] su6_r;
  vec_t u6_r;
  logic signed [CW-1:0] a6_r [3];

  always_ff @(posedge clk) begin
    det6_r <= TW'(pd_r[0]) + TW'(pd_r[1]) + TW'(pd_r[2]);
    for (int k = 0; k < 3; k++) begin
      m6_r[k] <= TW'(pm1_r[k]) - TW'(pm2_r[k]);
    end
    n6_r  <= n5_r;
    su6_r <= su5_r;
    u6_r  <= u5_r;
    a6_r  <= a5_r;
  end

  // ---------------- stage 7: partial products for u x m and su*n, flags
  limb4_t ml6 [3];
  limb3_t nl6 [3];
  limb3_t sul6;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ml6[k] = limbs4(m6_r[k]);
      nl6[k] = limbs3(SW'(n6_r[k]));
    end
  end

  assign sul6 = limbs3(su6_r);

  logic signed [2*DW-1:0] ppum_r [6][4];
  logic signed [2*DW-1:0] ppsn_r [3][3][3];
  logic signed [DENW-1:0] den7_r;
  logic                   deg7_r;
  logic signed [CW-1:0]   a7_r [3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      ppum_r[0][j] <= u6_r[1] * $signed(ml6[2][j]);
      ppum_r[1][j] <= u6_r[2] * $signed(ml6[1][j]);
      ppum_r[2][j] <= u6_r[2] * $signed(ml6[0][j]);
      ppum_r[3][j] <= u6_r[0] * $signed(ml6[2][j]);
      ppum_r[4][j] <= u6_r[0] * $signed(ml6[1][j]);
      ppum_r[5][j] <= u6_r[1] * $signed(ml6[0][j]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ppsn_r[k][i][j] <= $signed(sul6[i]) * $signed(nl6[k][j]);
        end
      end
    end
    den7_r <= {det6_r, 1'b0};
    deg7_r <= (det6_r == '0);
    a7_r   <= a6_r;
  end

  // ---------------- stage 8: u x m products, rows of su*n
  logic signed [PW-1:0]  pum8_r [6];
  logic signed [SNW-1:0] rsn8_r [3][3];
  logic signed [DENW-1:0] den8_r;
  logic                   deg8_r;
  logic signed [CW-1:0]   a8_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      pum8_r[i] <= PW'(ppum_r[i][0]) + (PW'(ppum_r[i][1]) <<< 32) +
                   (PW'(ppum_r[i][2]) <<< 64) + (PW'(ppum_r[i][3]) <<< 96);
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        rsn8_r[k][i] <= SNW'(ppsn_r[k][i][0]) + (SNW'(ppsn_r[k][i][1]) <<< 32) +
                        (SNW'(ppsn_r[k][i][2]) <<< 64);
      end
    end
    den8_r <= den7_r;
    deg8_r <= deg7_r;
    a8_r   <= a7_r;
  end

  // ---------------- stage 9: su*n
  logic signed [PW-1:0]   pum9_r [6];
  logic signed [SNW-1:0]  psn9_r [3];
  logic signed [DENW-1:0] den9_r;
  logic                   deg9_r;
  logic signed [CW-1:0]   a9_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      psn9_r[k] <= rsn8_r[k][0] + (rsn8_r[k][1] <<< 32) + (rsn8_r[k][2] <<< 64);
    end
    pum9_r <= pum8_r;
    den9_r <= den8_r;
    deg9_r <= deg8_r;
    a9_r   <= a8_r;
  end

  // ---------------- stage 10: numerators
  logic signed [NUMW-1:0] num10_r [3];
  logic signed [DENW-1:0] den10_r;
  logic                   deg10_r;
  logic signed [CW-1:0]   a10_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num10_r[k] <= NUMW'(psn9_r[k]) + NUMW'(pum9_r[2*k]) - NUMW'(pum9_r[2*k+1]);
    end
    den10_r <= den9_r;
    deg10_r <= deg9_r;
    a10_r   <= a9_r;
  end

  // ---------------- stage 11: magnitudes, sign, quotient overflow
  logic [DENW-1:0] dmag8;
  assign dmag8 = den10_r[DENW-1] ? DENW'($unsigned(-den10_r)) : DENW'($unsigned(den10_r));

  div_t dv_r [QW+1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dv_r[0].rem[k] <= num10_r[k][NUMW-1] ? NUMW'($unsigned(-num10_r[k]))
                                           : NUMW'($unsigned(num10_r[k]));
      dv_r[0].neg[k] <= num10_r[k][NUMW-1] ^ den10_r[DENW-1];
      dv_r[0].ovf[k] <= (num10_r[k][NUMW-1] ? NUMW'($unsigned(-num10_r[k]))
                                            : NUMW'($unsigned(num10_r[k])))
                        >= (NUMW'(dmag8) << QW);
      dv_r[0].a[k]   <= a10_r[k];
    end
    dv_r[0].quo  <= '0;
    dv_r[0].dmag <= dmag8;
    dv_r[0].deg  <= deg10_r;
  end

  // ---------------- restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NUMW-1:0] dsh;
    div_t            dv_nxt;
    assign dsh = NUMW'(dv_r[j].dmag) << B;

    always_comb begin
      dv_nxt = dv_r[j];
      for (int k = 0; k < 3; k++) begin
        if (dv_r[j].rem[k] >= dsh) begin
          dv_nxt.rem[k]    = dv_r[j].rem[k] - dsh;
          dv_nxt.quo[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_r[j+1] <= dv_nxt;
    end
  end

  // ---------------- round to nearest, ties away from zero
  logic [2:0][QW:0]     mag_r;
  logic [2:0]           rneg_r, rovf_r;
  logic                 rdeg_r;
  logic [2:0][CW-1:0]   ra_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= (QW+1)'(dv_r[QW].quo[k]) +
                  (QW+1)'({dv_r[QW].rem[k][DENW-1:0], 1'b0} >= {1'b0, dv_r[QW].dmag});
    end
    rneg_r <= dv_r[QW].neg;
    rovf_r <= dv_r[QW].ovf;
    rdeg_r <= dv_r[QW].deg;
    ra_r   <= dv_r[QW].a;
  end

  // ---------------- center with saturation, squares of the offset
  logic signed [EW-1:0] csum [3];
  logic [2:0][CW-1:0]   cen_r;
  logic [2:0][63:0]     sq_r;
  logic [2:0]           big_r;
  logic                 xdeg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = EW'($signed(ra_r[k])) +
                (rneg_r[k] ? -$signed({1'b0, mag_r[k]}) : $signed({1'b0, mag_r[k]}));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (rdeg_r) begin
        cen_r[k] <= '0;
      end else if (rovf_r[k]) begin
        cen_r[k] <= {rneg_r[k], {(CW-1){~rneg_r[k]}}};
      end else if ((csum[k][EW-1:CW-1] == '0) || (csum[k][EW-1:CW-1] == '1)) begin
        cen_r[k] <= csum[k][CW-1:0];
      end else begin
        cen_r[k] <= {csum[k][EW-1], {(CW-1){~csum[k][EW-1]}}};
      end
      sq_r[k]  <= mag_r[k][31:0] * mag_r[k][31:0];
      big_r[k] <= rovf_r[k] || (mag_r[k][QW:32] != '0);
    end
    xdeg_r <= rdeg_r;
  end

  // ---------------- squared radius, saturating, into the output register
  logic [65:0] rsum;
  assign rsum = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);

  out_item_t out_r;

  always_ff @(posedge clk) begin
    out_r.center_x   <= cen_r[0];
    out_r.center_y   <= cen_r[1];
    out_r.center_z   <= cen_r[2];
    out_r.degenerate <= xdeg_r;
    if (xdeg_r) begin
      out_r.radius_squared <= '0;
    end else if ((big_r != '0) || (rsum[65:RW] != '0)) begin
      out_r.radius_squared <= '1;
    end else begin
      out_r.radius_squared <= rsum[RW-1:0];
    end
  end

  assign out_item = out_r;

  // ---------------- checks
  `TCC_ASSERT_DLY(a_fixed_latency, clk, rst_n, start && !busy, LAT, out_valid,
                  "accepted item did not produce a result after the pipeline latency")
  `TCC_ASSERT_NOW(a_degenerate_zero, clk, rst_n, out_valid && out_item.degenerate,
                  (out_item.radius_squared == '0) && (out_item.center_x == '0) &&
                  (out_item.center_y == '0) && (out_item.center_z == '0),
                  "degenerate result carries nonzero fields")
  `TCC_ASSERT_NOW(a_never_busy, clk, rst_n, 1'b1, !busy,
                  "core signaled busy")

endmodule
